[rtl/uets_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// uets_pkg
// Shared types and constants of the USB endpoint transfer segmenter.
// ---------------------------------------------------------------------------
package uets_pkg;

    // endpoint and storage geometry
    localparam int ENDPOINT_COUNT = 4;
    localparam int EP_W           = 2;
    localparam int EP_IDX_W       = (ENDPOINT_COUNT > 1) ? $clog2(ENDPOINT_COUNT) : 1;
    localparam int MEM_DEPTH      = 1 << EP_IDX_W;
    localparam logic [EP_W:0] EP_LIMIT = (EP_W + 1)'(ENDPOINT_COUNT);

    // data widths
    localparam int DATA_W  = 32;
    localparam int MPS_W   = 11;
    localparam int OP_W    = 3;
    localparam int ACT_W   = 3;

    // register file
    localparam int MPS_COUNT   = 4;
    localparam int REG_COUNT   = 8;
    localparam int REG_IDX_W   = 3;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam logic [MPS_W-1:0] MPS_RESET = 11'd64;

    // register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_IN_MPS_0  = 3'd0,
        REG_IN_MPS_1  = 3'd1,
        REG_IN_MPS_2  = 3'd2,
        REG_IN_MPS_3  = 3'd3,
        REG_OUT_MPS_0 = 3'd4,
        REG_OUT_MPS_1 = 3'd5,
        REG_OUT_MPS_2 = 3'd6,
        REG_OUT_MPS_3 = 3'd7
    } reg_idx_t;

    // command codes
    typedef enum logic [OP_W-1:0] {
        OP_START_IN      = 3'd0,
        OP_START_OUT_LEN = 3'd1,
        OP_START_OUT_ONE = 3'd2,
        OP_IN_DONE       = 3'd3,
        OP_OUT_DONE      = 3'd4,
        OP_BUS_RESET     = 3'd5
    } op_t;

    // result actions
    typedef enum logic [ACT_W-1:0] {
        ACT_FLUSH   = 3'd0,
        ACT_SEND_IN = 3'd1,
        ACT_ARM_OUT = 3'd2,
        ACT_TX_DONE = 3'd3,
        ACT_RX_DONE = 3'd4
    } act_t;

    // command beat
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [EP_W-1:0]   endpoint;
        logic [DATA_W-1:0] buffer_address;
        logic [DATA_W-1:0] transfer_length;
        logic [MPS_W-1:0]  received_count;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [EP_W-1:0]   target_endpoint;
        logic              is_in_direction;
        logic [DATA_W-1:0] packet_address;
        logic [DATA_W-1:0] byte_count;
        logic              last;
    } result_t;

    // max packet sizes handed from the register file to the engine
    typedef struct packed {
        logic [MPS_COUNT-1:0][MPS_W-1:0] in_mps;
        logic [MPS_COUNT-1:0][MPS_W-1:0] out_mps;
    } mps_set_t;

endpackage
`default_nettype wire

[rtl/uets_regs.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// uets_regs
// APB register file holding the IN and OUT max packet sizes.
// ---------------------------------------------------------------------------
module uets_regs
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [uets_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [uets_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [uets_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output uets_pkg::mps_set_t                   mps
);

    logic [uets_pkg::MPS_COUNT-1:0][uets_pkg::MPS_W-1:0] in_mps_reg;
    logic [uets_pkg::MPS_COUNT-1:0][uets_pkg::MPS_W-1:0] out_mps_reg;
    logic [uets_pkg::REG_IDX_W-1:0]                      reg_idx;
    logic                                                wr_en;
    logic [uets_pkg::MPS_W-1:0]                          rd_val;

    assign pready  = 1'b1;
    assign reg_idx = paddr[uets_pkg::REG_IDX_W+1:2];
    assign wr_en   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < uets_pkg::MPS_COUNT; i++)
            begin
                in_mps_reg[i]  <= uets_pkg::MPS_RESET;
                out_mps_reg[i] <= uets_pkg::MPS_RESET;
            end
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                uets_pkg::REG_IN_MPS_0:  in_mps_reg[0]  <= pwdata[uets_pkg::MPS_W-1:0];
                uets_pkg::REG_IN_MPS_1:  in_mps_reg[1]  <= pwdata[uets_pkg::MPS_W-1:0];
                uets_pkg::REG_IN_MPS_2:  in_mps_reg[2]  <= pwdata[uets_pkg::MPS_W-1:0];
                uets_pkg::REG_IN_MPS_3:  in_mps_reg[3]  <= pwdata[uets_pkg::MPS_W-1:0];
                uets_pkg::REG_OUT_MPS_0: out_mps_reg[0] <= pwdata[uets_pkg::MPS_W-1:0];
                uets_pkg::REG_OUT_MPS_1: out_mps_reg[1] <= pwdata[uets_pkg::MPS_W-1:0];
                uets_pkg::REG_OUT_MPS_2: out_mps_reg[2] <= pwdata[uets_pkg::MPS_W-1:0];
                uets_pkg::REG_OUT_MPS_3: out_mps_reg[3] <= pwdata[uets_pkg::MPS_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            uets_pkg::REG_IN_MPS_0:  rd_val = in_mps_reg[0];
            uets_pkg::REG_IN_MPS_1:  rd_val = in_mps_reg[1];
            uets_pkg::REG_IN_MPS_2:  rd_val = in_mps_reg[2];
            uets_pkg::REG_IN_MPS_3:  rd_val = in_mps_reg[3];
            uets_pkg::REG_OUT_MPS_0: rd_val = out_mps_reg[0];
            uets_pkg::REG_OUT_MPS_1: rd_val = out_mps_reg[1];
            uets_pkg::REG_OUT_MPS_2: rd_val = out_mps_reg[2];
            uets_pkg::REG_OUT_MPS_3: rd_val = out_mps_reg[3];
            default:                 rd_val = '0;
        endcase
    end

    assign prdata      = uets_pkg::APB_DATA_W'(rd_val);
    assign mps.in_mps  = in_mps_reg;
    assign mps.out_mps = out_mps_reg;

endmodule
`default_nettype wire

[rtl/uets_engine.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// uets_engine
// Per-endpoint transfer state in a synchronous memory, read at accept and
// written back in the cycle after, together with the first result beat.
// ---------------------------------------------------------------------------
module uets_engine
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire uets_pkg::cmd_t     cmd,
    input  wire uets_pkg::mps_set_t mps,
    output logic                    busy,
    output uets_pkg::result_t       result,
    output logic                    result_strobe
);

    // one memory row per endpoint
    typedef struct packed {
        logic [uets_pkg::DATA_W-1:0] in_addr;
        logic [uets_pkg::DATA_W-1:0] in_rem;
        logic [uets_pkg::DATA_W-1:0] out_addr;
        logic [uets_pkg::DATA_W-1:0] out_rem;
        logic [uets_pkg::DATA_W-1:0] out_total;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXEC   = 3'b010,
        ST_SECOND = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    entry_t                         mem [uets_pkg::MEM_DEPTH];
    entry_t                         rdata_reg;
    logic [uets_pkg::MEM_DEPTH-1:0] valid_reg;
    uets_pkg::cmd_t                 cmd_reg;
    uets_pkg::result_t              result_reg, pending_reg;
    logic                           strobe_reg;

    logic                           accept;
    logic [uets_pkg::EP_IDX_W-1:0]  idx;
    logic                           ep_ok;
    entry_t                         cur;
    entry_t                         upd;
    logic                           upd_we;
    logic                           bus_reset;
    logic [1:0]                     n_res;
    uets_pkg::result_t              res0, res1, pkt;
    logic [uets_pkg::DATA_W-1:0]    in_mps32, out_mps32, len, buf_addr, new_total;
    logic                           flush;

    function automatic uets_pkg::result_t make_res(
        input uets_pkg::act_t              act,
        input logic [uets_pkg::EP_W-1:0]   ep,
        input logic                        dir,
        input logic [uets_pkg::DATA_W-1:0] addr,
        input logic [uets_pkg::DATA_W-1:0] cnt
    );
        uets_pkg::result_t r;
        r.action          = act;
        r.target_endpoint = ep;
        r.is_in_direction = dir;
        r.packet_address  = addr;
        r.byte_count      = cnt;
        r.last            = 1'b0;
        return r;
    endfunction

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign idx    = cmd_reg.endpoint[uets_pkg::EP_IDX_W-1:0];
    assign ep_ok  = ({1'b0, cmd_reg.endpoint} < uets_pkg::EP_LIMIT);

    // state memory: write-back and read at accept
    always_ff @(posedge clk)
    begin
        if (upd_we)
        begin
            mem[idx] <= upd;
        end
        if (accept)
        begin
            rdata_reg <= mem[cmd.endpoint[uets_pkg::EP_IDX_W-1:0]];
            cmd_reg   <= cmd;
        end
    end

    // row valid bits, cleared by reset and bus reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (bus_reset)
        begin
            valid_reg <= '0;
        end
        else if (upd_we)
        begin
            valid_reg[idx] <= 1'b1;
        end
    end

    // segmenting decision on the row read back
    always_comb
    begin
        cur       = valid_reg[idx] ? rdata_reg : '0;
        upd       = cur;
        upd_we    = 1'b0;
        bus_reset = 1'b0;
        n_res     = 2'd0;
        res0      = '0;
        res1      = '0;
        pkt       = '0;
        flush     = 1'b0;
        in_mps32  = uets_pkg::DATA_W'(mps.in_mps[cmd_reg.endpoint]);
        out_mps32 = uets_pkg::DATA_W'(mps.out_mps[cmd_reg.endpoint]);
        len       = cmd_reg.transfer_length;
        buf_addr  = cmd_reg.buffer_address;
        new_total = cur.out_total + uets_pkg::DATA_W'(cmd_reg.received_count);

        if (cmd_reg.operation == uets_pkg::OP_BUS_RESET)
        begin
            bus_reset = (state_reg == ST_EXEC);
        end
        else if (ep_ok)
        begin
            unique case (cmd_reg.operation)
                uets_pkg::OP_START_IN:
                begin
                    flush  = (cur.in_addr != '0);
                    upd_we = 1'b1;
                    if (len > in_mps32)
                    begin
                        upd.in_addr = buf_addr + in_mps32;
                        upd.in_rem  = len - in_mps32;
                        pkt = make_res(uets_pkg::ACT_SEND_IN, cmd_reg.endpoint, 1'b1,
                                       buf_addr, in_mps32);
                    end
                    else
                    begin
                        upd.in_addr = buf_addr;
                        upd.in_rem  = '0;
                        pkt = make_res(uets_pkg::ACT_SEND_IN, cmd_reg.endpoint, 1'b1,
                                       buf_addr, len);
                    end
                end
                uets_pkg::OP_START_OUT_LEN:
                begin
                    flush         = (cur.out_addr != '0);
                    upd_we        = 1'b1;
                    upd.out_total = '0;
                    if (len > out_mps32)
                    begin
                        upd.out_addr = buf_addr + out_mps32;
                        upd.out_rem  = len - out_mps32;
                        pkt = make_res(uets_pkg::ACT_ARM_OUT, cmd_reg.endpoint, 1'b0,
                                       buf_addr, out_mps32);
                    end
                    else
                    begin
                        upd.out_addr = buf_addr;
                        upd.out_rem  = '0;
                        pkt = make_res(uets_pkg::ACT_ARM_OUT, cmd_reg.endpoint, 1'b0,
                                       buf_addr, len);
                    end
                end
                uets_pkg::OP_START_OUT_ONE:
                begin
                    flush         = (cur.out_addr != '0);
                    upd_we        = 1'b1;
                    upd.out_addr  = buf_addr;
                    upd.out_rem   = '0;
                    upd.out_total = '0;
                    pkt = make_res(uets_pkg::ACT_ARM_OUT, cmd_reg.endpoint, 1'b0,
                                   buf_addr, out_mps32);
                end
                uets_pkg::OP_IN_DONE:
                begin
                    if (cur.in_addr != '0)
                    begin
                        upd_we = 1'b1;
                        n_res  = 2'd1;
                        if (cur.in_rem != '0)
                        begin
                            if (cur.in_rem > in_mps32)
                            begin
                                upd.in_addr = cur.in_addr + in_mps32;
                                upd.in_rem  = cur.in_rem - in_mps32;
                                res0 = make_res(uets_pkg::ACT_SEND_IN, cmd_reg.endpoint,
                                                1'b1, cur.in_addr, in_mps32);
                            end
                            else
                            begin
                                upd.in_rem = '0;
                                res0 = make_res(uets_pkg::ACT_SEND_IN, cmd_reg.endpoint,
                                                1'b1, cur.in_addr, cur.in_rem);
                            end
                        end
                        else
                        begin
                            upd.in_addr = '0;
                            res0 = make_res(uets_pkg::ACT_TX_DONE, cmd_reg.endpoint,
                                            1'b1, '0, '0);
                            // control endpoint arms its zero-length status stage
                            if (cmd_reg.endpoint == '0)
                            begin
                                n_res = 2'd2;
                                res1  = make_res(uets_pkg::ACT_ARM_OUT, '0, 1'b0, '0, '0);
                            end
                        end
                    end
                end
                uets_pkg::OP_OUT_DONE:
                begin
                    if (cur.out_addr != '0)
                    begin
                        upd_we        = 1'b1;
                        n_res         = 2'd1;
                        upd.out_total = new_total;
                        // short packet or nothing left ends the transfer
                        if ((uets_pkg::DATA_W'(cmd_reg.received_count) < out_mps32)
                            || (cur.out_rem == '0))
                        begin
                            upd.out_addr = '0;
                            res0 = make_res(uets_pkg::ACT_RX_DONE, cmd_reg.endpoint,
                                            1'b0, '0, new_total);
                        end
                        else if (cur.out_rem > out_mps32)
                        begin
                            upd.out_addr = cur.out_addr + out_mps32;
                            upd.out_rem  = cur.out_rem - out_mps32;
                            res0 = make_res(uets_pkg::ACT_ARM_OUT, cmd_reg.endpoint,
                                            1'b0, cur.out_addr, out_mps32);
                        end
                        else
                        begin
                            upd.out_rem = '0;
                            res0 = make_res(uets_pkg::ACT_ARM_OUT, cmd_reg.endpoint,
                                            1'b0, cur.out_addr, cur.out_rem);
                        end
                    end
                end
                default: ;
            endcase

            // start commands: optional flush ahead of the first packet
            if ((cmd_reg.operation == uets_pkg::OP_START_IN)
                || (cmd_reg.operation == uets_pkg::OP_START_OUT_LEN)
                || (cmd_reg.operation == uets_pkg::OP_START_OUT_ONE))
            begin
                if (flush)
                begin
                    n_res = 2'd2;
                    res0  = make_res(uets_pkg::ACT_FLUSH, cmd_reg.endpoint,
                                     (cmd_reg.operation == uets_pkg::OP_START_IN), '0, '0);
                    res1  = pkt;
                end
                else
                begin
                    n_res = 2'd1;
                    res0  = pkt;
                end
            end
        end

        // mark final beat
        if (n_res == 2'd1)
        begin
            res0.last = 1'b1;
        end
        if (n_res == 2'd2)
        begin
            res1.last = 1'b1;
        end

        upd_we = upd_we && (state_reg == ST_EXEC);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   state_next = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC:   state_next = (n_res == 2'd2) ? ST_SECOND : ST_IDLE;
            ST_SECOND: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= ((state_reg == ST_EXEC) && (n_res != 2'd0))
                          || (state_reg == ST_SECOND);
        end
    end

    // result beat registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            result_reg  <= res0;
            pending_reg <= res1;
        end
        else if (state_reg == ST_SECOND)
        begin
            result_reg <= pending_reg;
        end
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule
`default_nettype wire

[rtl/usb_endpoint_transfer_segmenter_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// usb_endpoint_transfer_segmenter_top
// Splits USB endpoint transfers into max-packet-size packets and reports
// flushes and transfer completion per endpoint and direction.
// ---------------------------------------------------------------------------
//  channel   ports                                  handshake
//  command   start, busy, cmd                       beat taken when start & !busy
//  result    result_strobe, result                  one-cycle strobe, no stall
//  config    psel, penable, pwrite, paddr, pwdata,  write on psel & penable &
//            prdata, pready                         pwrite, pready tied high
//
//  a command beat is taken at an edge that reads its state row from memory;
//  the row is written back with the first result beat in the cycle after
//  a command holds busy through ST_EXEC, and also through ST_SECOND when
//  it yields two result beats; the next command may follow on the edge
//  after busy falls; result beats are registered out of these states
//  rst_n clears the valid bits of all endpoint rows and restores the
//  max packet sizes to 64; a bus reset command clears the rows only
// ---------------------------------------------------------------------------
module usb_endpoint_transfer_segmenter_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire uets_pkg::cmd_t                  cmd,
    output uets_pkg::result_t                    result,
    output logic                                 result_strobe,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [uets_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [uets_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [uets_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    uets_pkg::mps_set_t mps;

    // max packet size registers
    uets_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mps     (mps)
    );

    // segmenting engine around the endpoint state memory
    uets_engine u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .mps           (mps),
        .busy          (busy),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule
`default_nettype wire

[dv/uets_segment_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// uets_segment_checker
// Watches the command, result and register ports of the transfer segmenter,
// keeps its own copy of the endpoint rows and max packet sizes, predicts the
// result beats of every accepted command and compares them in order.
// ---------------------------------------------------------------------------
module uets_segment_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire uets_pkg::cmd_t                  cmd,
    input  wire uets_pkg::result_t               result,
    input  wire logic                            result_strobe,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [uets_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [uets_pkg::APB_DATA_W-1:0] pwdata,
    output int                                   failure_count,
    output int                                   pending_beats
);

    // max packet sizes as last written
    logic [uets_pkg::MPS_W-1:0]  in_mps  [uets_pkg::ENDPOINT_COUNT];
    logic [uets_pkg::MPS_W-1:0]  out_mps [uets_pkg::ENDPOINT_COUNT];

    // per-endpoint transfer rows, zero address means idle
    logic [uets_pkg::DATA_W-1:0] in_addr   [uets_pkg::ENDPOINT_COUNT];
    logic [uets_pkg::DATA_W-1:0] in_left   [uets_pkg::ENDPOINT_COUNT];
    logic [uets_pkg::DATA_W-1:0] out_addr  [uets_pkg::ENDPOINT_COUNT];
    logic [uets_pkg::DATA_W-1:0] out_left  [uets_pkg::ENDPOINT_COUNT];
    logic [uets_pkg::DATA_W-1:0] out_total [uets_pkg::ENDPOINT_COUNT];

    // result beats still owed by the block, oldest first
    uets_pkg::result_t expected_beats [$];

    initial failure_count = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] segmenter check: %s", $time, msg);
        failure_count = failure_count + 1;
    endtask

    function automatic uets_pkg::result_t make_beat(
        input uets_pkg::act_t              act,
        input logic [uets_pkg::EP_W-1:0]   ep,
        input logic                        dir,
        input logic [uets_pkg::DATA_W-1:0] addr,
        input logic [uets_pkg::DATA_W-1:0] count
    );
        uets_pkg::result_t r;
        r.action          = act;
        r.target_endpoint = ep;
        r.is_in_direction = dir;
        r.packet_address  = addr;
        r.byte_count      = count;
        r.last            = 1'b0;
        return r;
    endfunction

    function automatic void clear_rows();
        for (int i = 0; i < uets_pkg::ENDPOINT_COUNT; i++)
        begin
            in_addr[i]   = '0;
            in_left[i]   = '0;
            out_addr[i]  = '0;
            out_left[i]  = '0;
            out_total[i] = '0;
        end
    endfunction

    // walk one command through the endpoint rows and queue its result beats
    function automatic void segment_command(input uets_pkg::cmd_t c);
        uets_pkg::result_t           beats [2];
        int                          n;
        logic [uets_pkg::EP_W-1:0]   ep;
        logic [uets_pkg::DATA_W-1:0] mps;
        logic [uets_pkg::DATA_W-1:0] len;
        logic [uets_pkg::DATA_W-1:0] buf_addr;
        logic [uets_pkg::DATA_W-1:0] a;
        logic [uets_pkg::DATA_W-1:0] cnt;
        n        = 0;
        ep       = c.endpoint;
        len      = c.transfer_length;
        buf_addr = c.buffer_address;
        cnt      = {{(uets_pkg::DATA_W-uets_pkg::MPS_W){1'b0}}, c.received_count};
        if (c.operation == uets_pkg::OP_BUS_RESET)
        begin
            clear_rows();
            return;
        end
        if (c.operation > uets_pkg::OP_BUS_RESET || ep >= uets_pkg::ENDPOINT_COUNT)
            return;
        case (c.operation)
            uets_pkg::OP_START_IN:
            begin
                mps = {{(uets_pkg::DATA_W-uets_pkg::MPS_W){1'b0}}, in_mps[ep]};
                if (in_addr[ep] != '0)
                begin
                    beats[n] = make_beat(uets_pkg::ACT_FLUSH, ep, 1'b1, '0, '0);
                    n++;
                end
                if (len > mps)
                begin
                    in_addr[ep] = buf_addr + mps;
                    in_left[ep] = len - mps;
                    beats[n] = make_beat(uets_pkg::ACT_SEND_IN, ep, 1'b1, buf_addr, mps);
                end
                else
                begin
                    in_addr[ep] = buf_addr;
                    in_left[ep] = '0;
                    beats[n] = make_beat(uets_pkg::ACT_SEND_IN, ep, 1'b1, buf_addr, len);
                end
                n++;
            end
            uets_pkg::OP_START_OUT_LEN:
            begin
                mps = {{(uets_pkg::DATA_W-uets_pkg::MPS_W){1'b0}}, out_mps[ep]};
                if (out_addr[ep] != '0)
                begin
                    beats[n] = make_beat(uets_pkg::ACT_FLUSH, ep, 1'b0, '0, '0);
                    n++;
                end
                out_total[ep] = '0;
                if (len > mps)
                begin
                    out_addr[ep] = buf_addr + mps;
                    out_left[ep] = len - mps;
                    beats[n] = make_beat(uets_pkg::ACT_ARM_OUT, ep, 1'b0, buf_addr, mps);
                end
                else
                begin
                    out_addr[ep] = buf_addr;
                    out_left[ep] = '0;
                    beats[n] = make_beat(uets_pkg::ACT_ARM_OUT, ep, 1'b0, buf_addr, len);
                end
                n++;
            end
            uets_pkg::OP_START_OUT_ONE:
            begin
                mps = {{(uets_pkg::DATA_W-uets_pkg::MPS_W){1'b0}}, out_mps[ep]};
                if (out_addr[ep] != '0)
                begin
                    beats[n] = make_beat(uets_pkg::ACT_FLUSH, ep, 1'b0, '0, '0);
                    n++;
                end
                out_addr[ep]  = buf_addr;
                out_left[ep]  = '0;
                out_total[ep] = '0;
                beats[n] = make_beat(uets_pkg::ACT_ARM_OUT, ep, 1'b0, buf_addr, mps);
                n++;
            end
            uets_pkg::OP_IN_DONE:
            begin
                if (in_addr[ep] == '0)
                    return;
                mps = {{(uets_pkg::DATA_W-uets_pkg::MPS_W){1'b0}}, in_mps[ep]};
                if (in_left[ep] != '0)
                begin
                    a = in_addr[ep];
                    if (in_left[ep] > mps)
                    begin
                        beats[n] = make_beat(uets_pkg::ACT_SEND_IN, ep, 1'b1, a, mps);
                        in_addr[ep] = a + mps;
                        in_left[ep] = in_left[ep] - mps;
                    end
                    else
                    begin
                        beats[n] = make_beat(uets_pkg::ACT_SEND_IN, ep, 1'b1, a,
                                             in_left[ep]);
                        in_left[ep] = '0;
                    end
                    n++;
                end
                else
                begin
                    // transfer over; endpoint 0 also arms the status stage
                    in_addr[ep] = '0;
                    beats[n] = make_beat(uets_pkg::ACT_TX_DONE, ep, 1'b1, '0, '0);
                    n++;
                    if (ep == '0)
                    begin
                        beats[n] = make_beat(uets_pkg::ACT_ARM_OUT, '0, 1'b0, '0, '0);
                        n++;
                    end
                end
            end
            uets_pkg::OP_OUT_DONE:
            begin
                if (out_addr[ep] == '0)
                    return;
                mps = {{(uets_pkg::DATA_W-uets_pkg::MPS_W){1'b0}}, out_mps[ep]};
                out_total[ep] = out_total[ep] + cnt;
                // short packet or nothing left ends the transfer
                if (cnt < mps || out_left[ep] == '0)
                begin
                    out_addr[ep] = '0;
                    beats[n] = make_beat(uets_pkg::ACT_RX_DONE, ep, 1'b0, '0,
                                         out_total[ep]);
                end
                else
                begin
                    a = out_addr[ep];
                    if (out_left[ep] > mps)
                    begin
                        beats[n] = make_beat(uets_pkg::ACT_ARM_OUT, ep, 1'b0, a, mps);
                        out_addr[ep] = a + mps;
                        out_left[ep] = out_left[ep] - mps;
                    end
                    else
                    begin
                        beats[n] = make_beat(uets_pkg::ACT_ARM_OUT, ep, 1'b0, a,
                                             out_left[ep]);
                        out_left[ep] = '0;
                    end
                end
                n++;
            end
            default:
            begin
            end
        endcase
        if (n > 0)
            beats[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_beats.push_back(beats[i]);
    endfunction

    // compare one result beat with the oldest expected one
    task automatic check_beat(input uets_pkg::result_t got);
        uets_pkg::result_t want;
        if (expected_beats.size() == 0)
        begin
            report_mismatch($sformatf("result beat with none expected: action %0d ep %0d",
                                      got.action, got.target_endpoint));
            return;
        end
        want = expected_beats.pop_front();
        if (got.action !== want.action)
            report_mismatch($sformatf("action %0d, expected %0d", got.action, want.action));
        if (got.target_endpoint !== want.target_endpoint)
            report_mismatch($sformatf("target_endpoint %0d, expected %0d",
                                      got.target_endpoint, want.target_endpoint));
        if (got.is_in_direction !== want.is_in_direction)
            report_mismatch($sformatf("is_in_direction %b, expected %b",
                                      got.is_in_direction, want.is_in_direction));
        if (got.packet_address !== want.packet_address)
            report_mismatch($sformatf("packet_address %h, expected %h",
                                      got.packet_address, want.packet_address));
        if (got.byte_count !== want.byte_count)
            report_mismatch($sformatf("byte_count %h, expected %h",
                                      got.byte_count, want.byte_count));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    endtask

    // register write snoop
    task automatic capture_mps_write(input logic [uets_pkg::APB_ADDR_W-1:0] addr,
                                     input logic [uets_pkg::APB_DATA_W-1:0] data);
        uets_pkg::reg_idx_t sel;
        sel = uets_pkg::reg_idx_t'(addr[uets_pkg::APB_ADDR_W-1:2]);
        if (sel <= uets_pkg::REG_IN_MPS_3)
            in_mps[sel[1:0]] = data[uets_pkg::MPS_W-1:0];
        else
            out_mps[sel[1:0]] = data[uets_pkg::MPS_W-1:0];
    endtask

    // sample all channels on the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < uets_pkg::ENDPOINT_COUNT; i++)
            begin
                in_mps[i]  = uets_pkg::MPS_RESET;
                out_mps[i] = uets_pkg::MPS_RESET;
            end
            clear_rows();
            expected_beats.delete();
            pending_beats = 0;
        end
        else
        begin
            if (result_strobe)
                check_beat(result);
            if (psel && penable && pwrite && pready)
                capture_mps_write(paddr, pwdata);
            if (start && !busy)
                segment_command(cmd);
            pending_beats = expected_beats.size();
        end
    end

endmodule

[dv/usb_endpoint_transfer_segmenter_top_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// usb_endpoint_transfer_segmenter_top_tb
// Drives directed and random transfer commands and max-packet-size settings
// into the segmenter with random gaps; a checker beside the block predicts
// and compares every result beat, and this top gives the verdict.
// ---------------------------------------------------------------------------
module usb_endpoint_transfer_segmenter_top_tb;

    // reserved command codes the block must ignore
    localparam logic [uets_pkg::OP_W-1:0] OP_RESERVED_LO = 3'd6;
    localparam logic [uets_pkg::OP_W-1:0] OP_RESERVED_HI = 3'd7;

    localparam int DRAIN_LIMIT  = 400;
    localparam int SETTLE_TICKS = 8;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    uets_pkg::cmd_t                  cmd;
    uets_pkg::result_t               result;
    logic                            result_strobe;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [uets_pkg::APB_ADDR_W-1:0] paddr;
    logic [uets_pkg::APB_DATA_W-1:0] pwdata;
    logic [uets_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    int                              failure_count;
    int                              pending_beats;

    // stimulus bookkeeping
    int                        cur_in_mps  [uets_pkg::ENDPOINT_COUNT];
    int                        cur_out_mps [uets_pkg::ENDPOINT_COUNT];
    logic [uets_pkg::EP_W-1:0] last_in_ep;
    logic [uets_pkg::EP_W-1:0] last_out_ep;
    int                        burst_left;

    usb_endpoint_transfer_segmenter_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .result        (result),
        .result_strobe (result_strobe),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    uets_segment_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .result        (result),
        .result_strobe (result_strobe),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .failure_count (failure_count),
        .pending_beats (pending_beats)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // one command beat, held until the block takes it
    task automatic send_cmd(input logic [uets_pkg::OP_W-1:0]   op,
                            input logic [uets_pkg::EP_W-1:0]   ep,
                            input logic [uets_pkg::DATA_W-1:0] addr,
                            input logic [uets_pkg::DATA_W-1:0] len,
                            input logic [uets_pkg::MPS_W-1:0]  count);
        uets_pkg::cmd_t c;
        c.operation       = op;
        c.endpoint        = ep;
        c.buffer_address  = addr;
        c.transfer_length = len;
        c.received_count  = count;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // mostly short gaps, a few long ones, and bursts with none
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_and_gap(input logic [uets_pkg::OP_W-1:0]   op,
                                input logic [uets_pkg::EP_W-1:0]   ep,
                                input logic [uets_pkg::DATA_W-1:0] addr,
                                input logic [uets_pkg::DATA_W-1:0] len,
                                input logic [uets_pkg::MPS_W-1:0]  count);
        send_cmd(op, ep, addr, len, count);
        idle_cycles(pick_gap());
    endtask

    // hold off until every owed result beat has come, then let the block settle
    task automatic wait_results_done();
        int k;
        k = 0;
        idle_cycles(1);
        while (pending_beats != 0 && k < DRAIN_LIMIT)
        begin
            idle_cycles(1);
            k++;
        end
        idle_cycles(SETTLE_TICKS);
    endtask

    // register write with an APB setup phase and then an access phase
    task automatic reg_write(input uets_pkg::reg_idx_t idx,
                             input logic [uets_pkg::MPS_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(uets_pkg::APB_DATA_W-uets_pkg::MPS_W){1'b0}}, val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= uets_pkg::REG_IN_MPS_3)
            cur_in_mps[idx[1:0]] = val;
        else
            cur_out_mps[idx[1:0]] = val;
    endtask

    function automatic logic [uets_pkg::MPS_W-1:0] pick_mps(input int phase);
        int r;
        case (phase)
            1: return 11'd1024;
            2: return 11'd0;
            3: return uets_pkg::MPS_W'($urandom_range(1, 8));
            4: return uets_pkg::MPS_W'($urandom_range(0, 1024));
            default:
            begin
                r = $urandom_range(0, 5);
                case (r)
                    0: return 11'd0;
                    1: return 11'd1;
                    2: return 11'd1023;
                    3: return 11'd1024;
                    default: return uets_pkg::MPS_W'($urandom_range(0, 1024));
                endcase
            end
        endcase
    endfunction

    function automatic logic [uets_pkg::DATA_W-1:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 12)
            return 32'hFFFF_F000 | $urandom_range(0, 32'hFFF);
        return $urandom;
    endfunction

    function automatic logic [uets_pkg::DATA_W-1:0] pick_len(input int mps);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return $urandom;
        if (r < 16)
            return '0;
        if (r < 30)
            return mps * $urandom_range(1, 4);
        return $urandom_range(0, 4 * mps + 16);
    endfunction

    function automatic logic [uets_pkg::MPS_W-1:0] pick_count(input int mps);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return uets_pkg::MPS_W'(mps);
        if (r < 75)
            return uets_pkg::MPS_W'($urandom_range(0, mps));
        if (r < 85)
            return uets_pkg::MPS_W'($urandom_range(0, 1024));
        if (r < 93)
            return 11'd1024;
        return '0;
    endfunction

    // random commands: starts, and done events that mostly follow the last start in their direction
    task automatic random_commands(input int n);
        int                        sent;
        int                        r;
        logic [uets_pkg::EP_W-1:0] ep;
        sent = 0;
        while (sent < n)
        begin
            r  = $urandom_range(0, 99);
            ep = uets_pkg::EP_W'($urandom_range(0, uets_pkg::ENDPOINT_COUNT - 1));
            if (r < 12)
            begin
                last_in_ep = ep;
                send_and_gap(uets_pkg::OP_START_IN, ep, pick_addr(),
                             pick_len(cur_in_mps[ep]),
                             uets_pkg::MPS_W'($urandom_range(0, 1024)));
                sent++;
            end
            else if (r < 25)
            begin
                last_out_ep = ep;
                send_and_gap((r < 20) ? uets_pkg::OP_START_OUT_LEN
                                      : uets_pkg::OP_START_OUT_ONE, ep,
                             pick_addr(), pick_len(cur_out_mps[ep]),
                             uets_pkg::MPS_W'($urandom_range(0, 1024)));
                sent++;
            end
            else if (r < 60)
            begin
                if ($urandom_range(0, 9) < 6)
                    ep = last_in_ep;
                send_and_gap(uets_pkg::OP_IN_DONE, ep, $urandom, $urandom,
                             uets_pkg::MPS_W'($urandom_range(0, 1024)));
                sent++;
            end
            else if (r < 95)
            begin
                if ($urandom_range(0, 9) < 6)
                    ep = last_out_ep;
                send_and_gap(uets_pkg::OP_OUT_DONE, ep, $urandom, $urandom,
                             pick_count(cur_out_mps[ep]));
                sent++;
            end
            else if (r < 97)
                send_and_gap(uets_pkg::OP_BUS_RESET, ep, $urandom, $urandom,
                             uets_pkg::MPS_W'($urandom_range(0, 1024)));
            else
                send_and_gap((r < 99) ? OP_RESERVED_LO : OP_RESERVED_HI, ep, $urandom,
                             $urandom, uets_pkg::MPS_W'($urandom_range(0, 1024)));
            // occasional full stop until the block has answered everything
            if ($urandom_range(0, 99) < 3)
                wait_results_done();
        end
    endtask

    // directed sequences over the special cases, default packet size 64
    task automatic directed_commands();
        // multi-packet IN transfer on endpoint 1
        send_and_gap(uets_pkg::OP_START_IN, 2'd1, 32'h0000_1000, 32'd150, 11'd0);
        send_and_gap(uets_pkg::OP_IN_DONE, 2'd1, '0, '0, 11'd0);
        send_and_gap(uets_pkg::OP_IN_DONE, 2'd1, '0, '0, 11'd0);
        send_and_gap(uets_pkg::OP_IN_DONE, 2'd1, '0, '0, 11'd0);
        // zero-length IN on endpoint 0, then status receive
        send_and_gap(uets_pkg::OP_START_IN, 2'd0, 32'h0000_0400, 32'd0, 11'd1024);
        send_and_gap(uets_pkg::OP_IN_DONE, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1024);
        // restart while busy, and an address that wraps to zero
        send_and_gap(uets_pkg::OP_START_IN, 2'd2, 32'h0000_3000, 32'hFFFF_FFFF, 11'd0);
        send_and_gap(uets_pkg::OP_START_IN, 2'd2, 32'hFFFF_FFC0, 32'd200, 11'd0);
        send_and_gap(uets_pkg::OP_IN_DONE, 2'd2, '0, '0, 11'd0);
        // OUT transfer ended by a short packet
        send_and_gap(uets_pkg::OP_START_OUT_LEN, 2'd1, 32'h0000_2000, 32'd200, 11'd0);
        send_and_gap(uets_pkg::OP_OUT_DONE, 2'd1, '0, '0, 11'd64);
        send_and_gap(uets_pkg::OP_OUT_DONE, 2'd1, '0, '0, 11'd10);
        // single-packet OUT, restarted while busy, full packet ends it
        send_and_gap(uets_pkg::OP_START_OUT_ONE, 2'd3, 32'hFFFF_FFFF, '0, 11'd0);
        send_and_gap(uets_pkg::OP_START_OUT_ONE, 2'd3, 32'h0000_5000, 32'hFFFF_FFFF,
                     11'd0);
        send_and_gap(uets_pkg::OP_OUT_DONE, 2'd3, '0, '0, 11'd1024);
        send_and_gap(uets_pkg::OP_OUT_DONE, 2'd3, '0, '0, 11'd64);
        // null buffer leaves the direction idle
        send_and_gap(uets_pkg::OP_START_IN, 2'd3, '0, 32'd10, 11'd0);
        send_and_gap(uets_pkg::OP_IN_DONE, 2'd3, '0, '0, 11'd0);
        // OUT transfer ended by running out of length
        send_and_gap(uets_pkg::OP_START_OUT_LEN, 2'd2, 32'h0000_7000, 32'd128, 11'd0);
        send_and_gap(uets_pkg::OP_OUT_DONE, 2'd2, '0, '0, 11'd64);
        send_and_gap(uets_pkg::OP_OUT_DONE, 2'd2, '0, '0, 11'd64);
        // reserved codes are ignored
        send_and_gap(OP_RESERVED_LO, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1024);
        send_and_gap(OP_RESERVED_HI, 2'd3, 32'h1234_5678, 32'd1, 11'd1);
        // bus reset drops a pending OUT transfer
        send_and_gap(uets_pkg::OP_START_OUT_LEN, 2'd0, 32'h0000_0100, '0, 11'd0);
        send_and_gap(uets_pkg::OP_BUS_RESET, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1024);
        send_and_gap(uets_pkg::OP_OUT_DONE, 2'd0, '0, '0, 11'd0);
    endtask

    // stimulus and verdict
    initial
    begin
        start      = 1'b0;
        cmd        = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        rst_n      = 1'b0;
        burst_left = 0;
        last_in_ep  = '0;
        last_out_ep = '0;
        for (int i = 0; i < uets_pkg::ENDPOINT_COUNT; i++)
        begin
            cur_in_mps[i]  = uets_pkg::MPS_RESET;
            cur_out_mps[i] = uets_pkg::MPS_RESET;
        end
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        directed_commands();
        random_commands(100);
        wait_results_done();

        // each phase rewrites every packet size, extremes first
        for (int phase = 1; phase <= 5; phase++)
        begin
            for (int i = 0; i < uets_pkg::REG_COUNT; i++)
                reg_write(uets_pkg::reg_idx_t'(uets_pkg::REG_IN_MPS_0 + i), pick_mps(phase));
            random_commands(105);
            wait_results_done();
        end

        if (failure_count == 0 && pending_beats == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
